[hw/rtl/ctdt_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package ctdt_pkg;

  localparam int unsigned IdW      = 32;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned WordW    = 32;
  localparam int unsigned PayloadW = 3 * WordW;
  localparam int unsigned TimeoutW = 16;
  localparam int unsigned ActionW  = 2;
  localparam int unsigned FreedW   = 5;

  localparam logic [TimeoutW-1:0] TimeoutReset = 16'd250;
  localparam logic [FreedW-1:0]   FreedMax     = 5'd31;

  localparam logic [ActionW-1:0] ActInsert  = 2'd0;
  localparam logic [ActionW-1:0] ActRefresh = 2'd1;
  localparam logic [ActionW-1:0] ActActive  = 2'd2;
  localparam logic [ActionW-1:0] ActFull    = 2'd3;

  typedef struct packed {
    logic [IdW-1:0]   id;
    logic [TimeW-1:0] expire;
  } key_entry_t;

  typedef struct packed {
    logic idle;
    logic load;
    logic rd_en;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic res_busy;
  } dp_status_t;

endpackage

`default_nettype wire

[hw/rtl/ctdt_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface ctdt_rpt_if;
  logic        valid;
  logic        ready;
  logic [31:0] object_id;
  logic [31:0] now_time;
  logic [31:0] vec_x;
  logic [31:0] vec_y;
  logic [31:0] vec_z;

  modport source (output valid, object_id, now_time, vec_x, vec_y, vec_z, input ready);
  modport sink   (input valid, object_id, now_time, vec_x, vec_y, vec_z, output ready);
endinterface

interface ctdt_res_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [4:0] freed_count;

  modport source (output valid, action, freed_count, input ready);
  modport sink   (input valid, action, freed_count, output ready);
endinterface

interface ctdt_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] timeout_ms;

  modport source (output valid, timeout_ms, input ready);
  modport sink   (input valid, timeout_ms, output ready);
endinterface

`default_nettype wire

[hw/rtl/ctdt_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module ctdt_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[hw/rtl/ctdt_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module ctdt_ctrl
  import ctdt_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       rpt_valid_i,
  input  wire dp_status_t status_i,
  output ctrl_cmd_t       cmd_o
);

  localparam logic [1:0] StIdle   = 2'd0;
  localparam logic [1:0] StScan   = 2'd1;
  localparam logic [1:0] StDrain  = 2'd2;
  localparam logic [1:0] StCommit = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        cmd_o.idle = 1'b1;
        if (rpt_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StScan;
        end
      end
      StScan: begin
        cmd_o.rd_en = 1'b1;
        if (status_i.scan_last) begin
          state_d = StDrain;
        end
      end
      StDrain: begin
        state_d = StCommit;
      end
      StCommit: begin
        if (!status_i.res_busy) begin
          cmd_o.commit = 1'b1;
          state_d      = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/ctdt_dp.sv]
`timescale 1ns / 1ps
`default_nettype none

module ctdt_dp
  import ctdt_pkg::*;
#(
  parameter int unsigned TableEntries = 16
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  ctdt_rpt_if.sink       rpt_i,
  ctdt_res_if.source     res_o,
  ctdt_cfg_if.sink       cfg_i,
  input  wire ctrl_cmd_t cmd_i,
  output dp_status_t     status_o
);

  localparam int unsigned IdxW = $clog2(TableEntries);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(TableEntries - 1);

  logic [TimeoutW-1:0] timeout_q;

  logic [IdW-1:0]      id_q;
  logic [TimeW-1:0]    now_q;
  logic [PayloadW-1:0] pay_q;

  logic [TableEntries-1:0] valid_q;

  logic [IdxW-1:0] addr_q;
  logic            chk_vld_q;
  logic [IdxW-1:0] chk_idx_q;

  logic            match_q;
  logic            match_exp_q;
  logic [IdxW-1:0] match_idx_q;
  logic            free_fnd_q;
  logic [IdxW-1:0] free_idx_q;
  logic [FreedW-1:0] freed_q;

  logic               res_vld_q;
  logic [ActionW-1:0] res_act_q;
  logic [FreedW-1:0]  res_freed_q;

  key_entry_t rd_key;
  key_entry_t wr_key;
  logic       ent_vld, hit, expired, freeing;
  logic       wr_en;
  logic [IdxW-1:0] wr_idx;
  logic [TimeW-1:0] new_expire;

  assign cfg_i.ready = 1'b1;
  assign rpt_i.ready = cmd_i.idle;

  assign status_o.scan_last = (addr_q == LastIdx);
  assign status_o.res_busy  = res_vld_q && !res_o.ready;

  assign res_o.valid       = res_vld_q;
  assign res_o.action      = res_act_q;
  assign res_o.freed_count = res_freed_q;

  assign ent_vld = valid_q[chk_idx_q];
  assign hit     = ent_vld && (rd_key.id == id_q);
  assign expired = rd_key.expire < now_q;
  assign freeing = chk_vld_q && ent_vld && !hit && expired;

  assign new_expire = now_q + {{(TimeW - TimeoutW){1'b0}}, timeout_q};

  always_comb begin
    wr_en  = 1'b0;
    wr_idx = free_idx_q;
    if (cmd_i.commit) begin
      if (match_q) begin
        wr_en  = match_exp_q;
        wr_idx = match_idx_q;
      end else begin
        wr_en = free_fnd_q;
      end
    end
  end

  assign wr_key.id     = id_q;
  assign wr_key.expire = new_expire;

  ctdt_ram #(
    .Width ($bits(key_entry_t)),
    .Depth (TableEntries)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_idx),
    .wdata_i (wr_key),
    .re_i    (cmd_i.rd_en),
    .raddr_i (addr_q),
    .rdata_o (rd_key)
  );

  ctdt_ram #(
    .Width (PayloadW),
    .Depth (TableEntries)
  ) u_pay_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_idx),
    .wdata_i (pay_q),
    .re_i    (1'b0),
    .raddr_i (wr_idx),
    .rdata_o ()
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TimeoutReset;
    end else if (cfg_i.valid) begin
      timeout_q <= cfg_i.timeout_ms;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      id_q  <= rpt_i.object_id;
      now_q <= rpt_i.now_time;
      pay_q <= {rpt_i.vec_z, rpt_i.vec_y, rpt_i.vec_x};
    end
    chk_idx_q <= addr_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q      <= '0;
      chk_vld_q   <= 1'b0;
      match_q     <= 1'b0;
      match_exp_q <= 1'b0;
      match_idx_q <= '0;
      free_fnd_q  <= 1'b0;
      free_idx_q  <= '0;
      freed_q     <= '0;
      valid_q     <= '0;
      res_vld_q   <= 1'b0;
      res_act_q   <= ActInsert;
      res_freed_q <= '0;
    end else begin
      chk_vld_q <= cmd_i.rd_en;

      if (cmd_i.load) begin
        addr_q     <= '0;
        match_q    <= 1'b0;
        free_fnd_q <= 1'b0;
        freed_q    <= '0;
      end else if (cmd_i.rd_en && !status_o.scan_last) begin
        addr_q <= addr_q + 1'b1;
      end

      if (chk_vld_q) begin
        if (hit && !match_q) begin
          match_q     <= 1'b1;
          match_exp_q <= expired;
          match_idx_q <= chk_idx_q;
        end
        if ((!ent_vld || freeing) && !free_fnd_q) begin
          free_fnd_q <= 1'b1;
          free_idx_q <= chk_idx_q;
        end
        if (freeing) begin
          valid_q[chk_idx_q] <= 1'b0;
          if (freed_q != FreedMax) begin
            freed_q <= freed_q + 1'b1;
          end
        end
      end

      if (cmd_i.commit) begin
        res_vld_q <= 1'b1;
      end else if (res_vld_q && res_o.ready) begin
        res_vld_q <= 1'b0;
      end

      if (cmd_i.commit) begin
        res_freed_q <= freed_q;
        if (match_q) begin
          res_act_q <= match_exp_q ? ActRefresh : ActActive;
        end else if (free_fnd_q) begin
          res_act_q           <= ActInsert;
          valid_q[free_idx_q] <= 1'b1;
        end else begin
          res_act_q <= ActFull;
        end
      end
    end
  end

endmodule

`default_nettype wire

[hw/rtl/contact_timeout_dedup_table_core.sv]
// Channel  Role  Transfer payload
// -------  ----  ----------------------------------------------
// rpt_i    sink  object_id, now_time, vec_x, vec_y, vec_z
// res_o    src   action, freed_count
// cfg_i    sink  timeout_ms (always ready)
//
// After a report's transfer, a single read port of the key RAM sweeps all entries,
// a drain state checks the last read, then a commit state updates the table and
// registers the result. A report is taken only in the idle state, so no new report
// is taken while the last one is still being swept or committed.
// Reset empties the table at once through per-entry valid flops; no clearing pass.
// A result waits in an output register; the next report is taken once the
// commit is done, and commit stalls only while a previous result is untaken.
`timescale 1ns / 1ps
`default_nettype none

module contact_timeout_dedup_table_core
  import ctdt_pkg::*;
#(
  parameter int unsigned TableEntries = 16
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  ctdt_rpt_if.sink   rpt_i,
  ctdt_res_if.source res_o,
  ctdt_cfg_if.sink   cfg_i
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  ctdt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rpt_valid_i (rpt_i.valid),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  ctdt_dp #(
    .TableEntries (TableEntries)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rpt_i    (rpt_i),
    .res_o    (res_o),
    .cfg_i    (cfg_i),
    .cmd_i    (cmd),
    .status_o (status)
  );

endmodule

`default_nettype wire

[tb/sv/ctdt_table_checker.sv]
`timescale 1ns / 1ps

module ctdt_table_checker
  import ctdt_pkg::*;
#(
  parameter int unsigned TableEntries = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                rpt_valid_i,
  input  logic                rpt_ready_i,
  input  logic [IdW-1:0]      rpt_id_i,
  input  logic [TimeW-1:0]    rpt_now_i,
  input  logic [PayloadW-1:0] rpt_payload_i,
  input  logic                res_valid_i,
  input  logic                res_ready_i,
  input  logic [ActionW-1:0]  res_action_i,
  input  logic [FreedW-1:0]   res_freed_i,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [TimeoutW-1:0] cfg_timeout_i,
  output int                  fail_cnt_o,
  output int                  pending_o
);

  typedef struct packed {
    logic [ActionW-1:0] action;
    logic [FreedW-1:0]  freed;
  } contact_res_t;

  logic                tbl_valid   [TableEntries];
  logic [IdW-1:0]      tbl_id      [TableEntries];
  logic [TimeW-1:0]    tbl_expire  [TableEntries];
  logic [PayloadW-1:0] tbl_payload [TableEntries];
  logic [TimeoutW-1:0] timeout_q;
  contact_res_t        pending_outcomes [$];

  task automatic flag_mismatch(input string msg);
    $display("[%0t] contact table: %s", $time, msg);
    fail_cnt_o++;
  endtask

  task automatic predict_contact(input logic [IdW-1:0] id, input logic [TimeW-1:0] now,
                                 input logic [PayloadW-1:0] payload,
                                 output contact_res_t res);
    int hit;
    int slot;
    logic [FreedW-1:0] freed;
    hit = -1;
    slot = -1;
    freed = '0;
    for (int i = 0; i < TableEntries; i++) begin
      if (hit < 0 && tbl_valid[i] && tbl_id[i] == id) hit = i;
    end
    // a matched entry is never reclaimed, only refreshed
    for (int i = 0; i < TableEntries; i++) begin
      if (i != hit && tbl_valid[i] && tbl_expire[i] < now) begin
        tbl_valid[i] = 1'b0;
        if (freed != FreedMax) freed++;
      end
    end
    if (hit >= 0) begin
      if (tbl_expire[hit] < now) begin
        tbl_expire[hit] = now + TimeW'(timeout_q);
        tbl_payload[hit] = payload;
        res.action = ActRefresh;
      end else begin
        res.action = ActActive;
      end
    end else begin
      for (int i = 0; i < TableEntries; i++) begin
        if (slot < 0 && !tbl_valid[i]) slot = i;
      end
      if (slot >= 0) begin
        tbl_valid[slot] = 1'b1;
        tbl_id[slot] = id;
        tbl_expire[slot] = now + TimeW'(timeout_q);
        tbl_payload[slot] = payload;
        res.action = ActInsert;
      end else begin
        res.action = ActFull;
      end
    end
    res.freed = freed;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    contact_res_t want;
    contact_res_t got;
    if (!rst_ni) begin
      for (int i = 0; i < TableEntries; i++) tbl_valid[i] = 1'b0;
      timeout_q = TimeoutReset;
      pending_outcomes.delete();
      fail_cnt_o = 0;
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) timeout_q = cfg_timeout_i;
      if (res_valid_i && res_ready_i) begin
        got.action = res_action_i;
        got.freed = res_freed_i;
        if (pending_outcomes.size() == 0) begin
          flag_mismatch($sformatf("unexpected result action=%0d freed=%0d",
                                  got.action, got.freed));
        end else begin
          want = pending_outcomes.pop_front();
          if (got.action != want.action)
            flag_mismatch($sformatf("action got %0d want %0d", got.action, want.action));
          if (got.freed != want.freed)
            flag_mismatch($sformatf("freed_count got %0d want %0d", got.freed, want.freed));
        end
      end
      if (rpt_valid_i && rpt_ready_i) begin
        predict_contact(rpt_id_i, rpt_now_i, rpt_payload_i, want);
        pending_outcomes.insert(pending_outcomes.size(), want);
      end
      pending_o <= pending_outcomes.size();
    end
  end

endmodule

[tb/sv/tb_contact_timeout_dedup_table_core.sv]
`timescale 1ns / 1ps

module tb_contact_timeout_dedup_table_core;
  import ctdt_pkg::*;

  localparam int unsigned TableEntries = 16;
  localparam int unsigned CycleLimit   = 600000;
  localparam int unsigned PoolSize     = 24;
  localparam logic [15:0] TimeoutPlan [8] = '{16'd0, 16'd65535, 16'd250, 16'd1000,
                                              16'd3, 16'd65535, 16'd40, 16'd0};

  logic        clk_i = 1'b0;
  logic        rst_ni;
  int          fail_cnt;
  int          pending;
  int unsigned cycles = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  ctdt_rpt_if rpt_if ();
  ctdt_res_if res_if ();
  ctdt_cfg_if cfg_if ();

  contact_timeout_dedup_table_core #(
    .TableEntries(TableEntries)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .rpt_i (rpt_if),
    .res_o (res_if),
    .cfg_i (cfg_if)
  );

  ctdt_table_checker #(
    .TableEntries(TableEntries)
  ) u_table_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rpt_valid_i  (rpt_if.valid),
    .rpt_ready_i  (rpt_if.ready),
    .rpt_id_i     (rpt_if.object_id),
    .rpt_now_i    (rpt_if.now_time),
    .rpt_payload_i({rpt_if.vec_x, rpt_if.vec_y, rpt_if.vec_z}),
    .res_valid_i  (res_if.valid),
    .res_ready_i  (res_if.ready),
    .res_action_i (res_if.action),
    .res_freed_i  (res_if.freed_count),
    .cfg_valid_i  (cfg_if.valid),
    .cfg_ready_i  (cfg_if.ready),
    .cfg_timeout_i(cfg_if.timeout_ms),
    .fail_cnt_o   (fail_cnt),
    .pending_o    (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // valid stays up across back-to-back transfers; it drops only on an idle cycle or in drain_results
  task automatic send_report(input logic [31:0] id, input logic [31:0] now,
                             input logic [31:0] vx, input logic [31:0] vy,
                             input logic [31:0] vz);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      rpt_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    rpt_if.valid     <= 1'b1;
    rpt_if.object_id <= id;
    rpt_if.now_time  <= now;
    rpt_if.vec_x     <= vx;
    rpt_if.vec_y     <= vy;
    rpt_if.vec_z     <= vz;
    do @(posedge clk_i); while (!rpt_if.ready);
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    rpt_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic write_timeout(input logic [15:0] tmo);
    @(negedge clk_i);
    cfg_if.valid      <= 1'b1;
    cfg_if.timeout_ms <= tmo;
    do @(posedge clk_i); while (!cfg_if.ready);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic run_random_reports(input int unsigned n_items, input logic [15:0] tmo);
    logic [31:0] id_pool [PoolSize];
    logic [31:0] now;
    logic [31:0] span;
    logic [31:0] step;
    logic [31:0] id;
    int unsigned r;
    for (int k = 0; k < PoolSize; k++) id_pool[k] = $urandom;
    id_pool[0] = '0;
    id_pool[1] = '1;
    span = 32'(tmo) + 32'd1;
    now = ($urandom_range(2) == 0) ? 32'd0 - $urandom_range(span * 4) : $urandom;
    for (int n = 0; n < n_items; n++) begin
      r = $urandom_range(99);
      if (r < 60) step = $urandom_range(span / 32);
      else if (r < 85) step = $urandom_range(span / 4);
      else if (r < 95) step = $urandom_range(span * 2);
      else step = $urandom;
      now = now + step;
      id = ($urandom_range(99) < 85) ? id_pool[$urandom_range(PoolSize - 1)] : $urandom;
      send_report(id, now, $urandom, $urandom, $urandom);
    end
  endtask

  initial begin
    logic [15:0] tmo;
    rst_ni = 1'b0;
    rpt_if.valid = 1'b0;
    rpt_if.object_id = '0;
    rpt_if.now_time = '0;
    rpt_if.vec_x = '0;
    rpt_if.vec_y = '0;
    rpt_if.vec_z = '0;
    cfg_if.valid = 1'b0;
    cfg_if.timeout_ms = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    write_timeout(16'd100);
    // insert, still active at the boundary, refresh just past it
    send_report(32'd0, 32'd0, '0, '0, '0);
    send_report(32'd0, 32'd100, '0, '0, '0);
    send_report(32'd0, 32'd101, $urandom, $urandom, $urandom);
    send_report('1, 32'd101, '1, '1, '1);
    for (int k = 1; k <= 14; k++) send_report(k, 32'd150, $urandom, $urandom, $urandom);
    // table full, then reclaim
    send_report(32'd20, 32'd150, $urandom, $urandom, $urandom);
    send_report(32'd21, 32'd250, $urandom, $urandom, $urandom);
    send_report(32'd1, 32'd300, $urandom, $urandom, $urandom);
    // expiry wraps past 2^32
    send_report(32'd5, 32'hFFFF_FFF0, $urandom, $urandom, $urandom);
    send_report(32'd5, 32'h0000_0010, $urandom, $urandom, $urandom);
    send_report(32'd5, 32'h0000_0060, $urandom, $urandom, $urandom);

    for (int ph = 0; ph < 8; ph++) begin
      drain_results();
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
        default: begin send_idle_pct = 15; recv_stall_pct = 15; end
      endcase
      tmo = (ph == 6) ? 16'($urandom_range(65535)) : TimeoutPlan[ph];
      write_timeout(tmo);
      run_random_reports(100, tmo);
      // hold off until the table has answered everything
      drain_results();
      run_random_reports(100, tmo);
    end

    drain_results();
    repeat ((TableEntries + 3) * 4) @(posedge clk_i);
    if (fail_cnt == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
